@@ sv/spd_pkg.sv @@
// Shared types, codes, constants and the CRC step for the servo packet deframer.
package spd_pkg;

  // Size of the packet store when the top level is not told otherwise.
  localparam int BUFFER_BYTES_DEF = 64;

  // Reset value of the buffer limit register.
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  // Header bytes and the sync pattern that precedes the final header byte.
  localparam logic [7:0]  HDR_FF   = 8'hFF;
  localparam logic [7:0]  HDR_FD   = 8'hFD;
  localparam logic [15:0] HDR_SYNC = 16'hFFFF;

  // CRC-16 generator polynomial, not reflected, initial value zero.
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Byte positions within a packet.
  localparam int POS_AFTER_HDR = 3;
  localparam int POS_ID        = 4;
  localparam int POS_LEN_LO    = 5;
  localparam int POS_LEN_HI    = 6;
  localparam int POS_INS       = 7;
  localparam int POS_PARAM0    = 8;

  // The shortest length field counts only the instruction and the two CRC bytes.
  localparam int MIN_LENGTH = 3;
  // Bytes outside the length field: header, reserved, ID and the two length bytes.
  localparam int FRAME_OVERHEAD = 7;
  // Offsets from the length field to the CRC bytes and the last parameter.
  localparam int CRC_LO_OFS     = 5;
  localparam int CRC_HI_OFS     = 6;
  localparam int LAST_PARAM_OFS = 4;

  // Result item kinds.
  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Packet status codes.
  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_CRC   = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  // One byte of CRC-16, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC after the three header bytes.
  localparam logic [15:0] CRC_HDR =
    crc16_byte(crc16_byte(crc16_byte(16'h0000, HDR_FF), HDR_FF), HDR_FD);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       hunt_shift;
    logic       hdr_start;
    logic       store_byte;
    logic       crc_upd;
    logic       enter_body;
    logic       drain_start;
    logic       drain_step;
    logic       clear;
    logic       load_out;
    logic       out_kind;
    logic [1:0] out_status;
    logic       out_with_ins;
    logic       out_with_count;
  } spd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_match;
    logic fld_last;
    logic len_short;
    logic len_long;
    logic body_crc;
    logic body_last;
    logic crc_ok;
    logic no_params;
    logic drain_last;
    logic out_free;
  } spd_stat_t;

endpackage

@@ sv/servo_packet_deframer_crc16.sv @@
// Top level of the servo bus packet deframer with CRC-16 check.
// Received bytes are taken one per cycle while hunting for the FF FF FD header and while
// collecting a packet; the only input stall during collection is on a byte that may close
// the packet while the previous result transaction is still waiting. A packet with a good
// CRC and parameters then stalls the input while each parameter byte is read through the
// registered store read port and sent, and then while the closing status is sent.
// Rejected and bad-CRC packets report their status in the cycle after the closing byte
// with no extra stall. The packet store needs no clearing after reset.
// The buffer limit register may only be written while no packet is in progress.
module servo_packet_deframer_crc16 import spd_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_item_kind,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_packet_id,
  output logic [7:0] out_instruction,
  output logic [5:0] out_param_count,
  output logic [1:0] out_packet_status,
  output logic       out_last_of_run
);

  spd_cmd_t  cmd;
  spd_stat_t stat;

  // Packet phase controller.
  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, CRC and result datapath.
  spd_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_item_kind     (out_item_kind),
    .out_param_byte    (out_param_byte),
    .out_packet_id     (out_packet_id),
    .out_instruction   (out_instruction),
    .out_param_count   (out_param_count),
    .out_packet_status (out_packet_status),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

@@ sv/spd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

@@ sv/spd_datapath.sv @@
// Datapath of the deframer: header sync, packet store, CRC, field capture and result register.
module spd_datapath import spd_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic [7:0] in_rx_byte,
  input  spd_cmd_t   cmd,
  output spd_stat_t  stat,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       out_item_kind,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_packet_id,
  output logic [7:0] out_instruction,
  output logic [5:0] out_param_count,
  output logic [1:0] out_packet_status,
  output logic       out_last_of_run
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [6:0]    limit_r;
  logic [15:0]   recent_r;
  logic [AW-1:0] idx_r;
  logic [15:0]   crc_r;
  logic [AW-1:0] len_r;
  logic [AW-1:0] ptr_r;
  logic [7:0]    len_lo_r;
  logic [7:0]    id_r;
  logic [7:0]    ins_r;
  logic [7:0]    prev_r;
  logic          out_valid_r;
  logic          out_kind_r;
  logic [7:0]    out_param_r;
  logic [7:0]    out_id_r;
  logic [7:0]    out_ins_r;
  logic [5:0]    out_count_r;
  logic [1:0]    out_status_r;

  logic [15:0]   len_full;
  logic [16:0]   len_sum;
  logic [AW:0]   len_bound;
  logic [7:0]    ram_rd_data;

  // Packet store: written at the byte position, read at the drain pointer.
  spd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_byte),
    .wr_addr (idx_r),
    .wr_data (in_rx_byte),
    .rd_addr (ptr_r),
    .rd_data (ram_rd_data)
  );

  // Length checks on the high byte as it arrives, and body position compares.
  assign len_full  = {in_rx_byte, len_lo_r};
  assign len_sum   = {1'b0, len_full} + 17'(FRAME_OVERHEAD);
  assign len_bound = {1'b0, len_r};

  always_comb begin
    stat.hdr_match  = (recent_r == HDR_SYNC) && (in_rx_byte == HDR_FD);
    stat.fld_last   = (idx_r == AW'(POS_LEN_HI));
    stat.len_short  = (len_full < 16'(MIN_LENGTH));
    stat.len_long   = (len_sum > {10'd0, limit_r}) || (len_sum > 17'(BUFFER_BYTES));
    stat.body_crc   = ({1'b0, idx_r} < len_bound + (AW+1)'(CRC_LO_OFS));
    stat.body_last  = ({1'b0, idx_r} == len_bound + (AW+1)'(CRC_HI_OFS));
    stat.crc_ok     = ({in_rx_byte, prev_r} == crc_r);
    stat.no_params  = (len_r == AW'(MIN_LENGTH));
    stat.drain_last = ({1'b0, ptr_r} == len_bound + (AW+1)'(LAST_PARAM_OFS));
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Control registers: limit, sync window, position, CRC, length, drain pointer, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      recent_r    <= '0;
      idx_r       <= '0;
      crc_r       <= '0;
      len_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        recent_r <= '0;
        idx_r    <= '0;
        crc_r    <= '0;
      end else begin
        if (cmd.hunt_shift) begin
          recent_r <= {recent_r[7:0], in_rx_byte};
        end
        if (cmd.hdr_start) begin
          recent_r <= '0;
          idx_r    <= AW'(POS_AFTER_HDR);
          crc_r    <= CRC_HDR;
        end
        if (cmd.store_byte) begin
          idx_r <= idx_r + AW'(1);
        end
        if (cmd.crc_upd) begin
          crc_r <= crc16_byte(crc_r, in_rx_byte);
        end
      end
      if (cmd.enter_body) begin
        len_r <= len_full[AW-1:0];
      end
      if (cmd.drain_start) begin
        ptr_r <= AW'(POS_PARAM0);
      end else if (cmd.drain_step) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured packet fields and the result payload.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      prev_r <= in_rx_byte;
      if (idx_r == AW'(POS_ID)) begin
        id_r <= in_rx_byte;
      end
      if (idx_r == AW'(POS_LEN_LO)) begin
        len_lo_r <= in_rx_byte;
      end
      if (idx_r == AW'(POS_INS)) begin
        ins_r <= in_rx_byte;
      end
    end
    if (cmd.load_out) begin
      out_kind_r   <= cmd.out_kind;
      out_param_r  <= (cmd.out_kind == KIND_PARAM) ? ram_rd_data : 8'h00;
      out_id_r     <= id_r;
      out_ins_r    <= cmd.out_with_ins ? ins_r : 8'h00;
      out_count_r  <= cmd.out_with_count ? 6'(len_r - AW'(MIN_LENGTH)) : 6'd0;
      out_status_r <= cmd.out_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_kind_r;
  assign out_param_byte    = out_param_r;
  assign out_packet_id     = out_id_r;
  assign out_instruction   = out_ins_r;
  assign out_param_count   = out_count_r;
  assign out_packet_status = out_status_r;
  assign out_last_of_run   = (out_kind_r == KIND_STATUS);

`ifndef SYNTH
  // The drain pointer never runs past the last parameter byte.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |-> ({1'b0, ptr_r} <= len_bound + (AW+1)'(LAST_PARAM_OFS)))
    else $error("drain pointer past last parameter");

  // Stored bytes always land inside the packet store.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_byte |-> ({1'b0, idx_r} < (AW+1)'(BUFFER_BYTES)))
    else $error("store position beyond buffer");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.load_out)
    else $error("result register overwritten while stalled");
`endif

endmodule

@@ sv/spd_ctrl.sv @@
// Controller state machine of the deframer: packet phases, parameter drain and result loading.
module spd_ctrl import spd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  spd_stat_t stat,
  output spd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_FIELDS,
    S_BODY,
    S_RD,
    S_EMIT,
    S_STAT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_phase;
  logic   may_emit;
  logic   acc;

  // Input is taken in the collecting phases; a byte that may close a packet waits for room.
  assign in_phase = (state_r == S_HUNT) || (state_r == S_FIELDS) || (state_r == S_BODY);
  assign may_emit = ((state_r == S_FIELDS) && stat.fld_last) ||
                    ((state_r == S_BODY) && stat.body_last);
  assign in_stall = !in_phase || (may_emit && !stat.out_free);
  assign acc      = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HUNT: begin
        if (acc) begin
          if (stat.hdr_match) begin
            cmd.hdr_start = 1'b1;
            state_nxt     = S_FIELDS;
          end else begin
            cmd.hunt_shift = 1'b1;
          end
        end
      end
      S_FIELDS: begin
        if (acc) begin
          cmd.store_byte = 1'b1;
          cmd.crc_upd    = 1'b1;
          if (stat.fld_last) begin
            if (stat.len_short || stat.len_long) begin
              cmd.load_out   = 1'b1;
              cmd.out_kind   = KIND_STATUS;
              cmd.out_status = stat.len_short ? ST_SHORT : ST_LONG;
              cmd.clear      = 1'b1;
              state_nxt      = S_HUNT;
            end else begin
              cmd.enter_body = 1'b1;
              state_nxt      = S_BODY;
            end
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          cmd.store_byte = 1'b1;
          cmd.crc_upd    = stat.body_crc;
          if (stat.body_last) begin
            if (!stat.crc_ok) begin
              cmd.load_out     = 1'b1;
              cmd.out_kind     = KIND_STATUS;
              cmd.out_status   = ST_CRC;
              cmd.out_with_ins = 1'b1;
              cmd.clear        = 1'b1;
              state_nxt        = S_HUNT;
            end else if (stat.no_params) begin
              cmd.load_out       = 1'b1;
              cmd.out_kind       = KIND_STATUS;
              cmd.out_status     = ST_GOOD;
              cmd.out_with_ins   = 1'b1;
              cmd.out_with_count = 1'b1;
              cmd.clear          = 1'b1;
              state_nxt          = S_HUNT;
            end else begin
              cmd.drain_start = 1'b1;
              state_nxt       = S_RD;
            end
          end
        end
      end
      S_RD: begin
        // The store read for the drain pointer completes in this cycle.
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_kind     = KIND_PARAM;
          cmd.out_status   = ST_GOOD;
          cmd.out_with_ins = 1'b1;
          cmd.drain_step   = 1'b1;
          state_nxt        = stat.drain_last ? S_STAT : S_RD;
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_out       = 1'b1;
          cmd.out_kind       = KIND_STATUS;
          cmd.out_status     = ST_GOOD;
          cmd.out_with_ins   = 1'b1;
          cmd.out_with_count = 1'b1;
          cmd.clear          = 1'b1;
          state_nxt          = S_HUNT;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // Every return to header hunting reports a packet status.
  a_clear_reports: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (cmd.load_out && (cmd.out_kind == KIND_STATUS)))
    else $error("packet closed without a status transaction");
`endif

endmodule
